/* rtl/core/motor_command_frame_parser_core_macros.svh */
// Assertion macros for the motor command frame parser.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef MOTOR_COMMAND_FRAME_PARSER_CORE_MACROS_SVH
`define MOTOR_COMMAND_FRAME_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MCFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("motor command frame parser check failed");
`define MCFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("motor command frame parser sequence check failed");
`else
`define MCFP_ASSERT(lbl, prop)
`define MCFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/mcfp_pkg.sv */
// Package for the motor command frame parser: phase type, command, mode
// and status codes, and the default payload bound. No dependencies.
package mcfp_pkg;

  localparam int unsigned MaxPayloadDefault = 16;

  localparam logic [7:0] HeaderByte = 8'hA1;

  localparam logic [7:0] CmdStop     = 8'h00;
  localparam logic [7:0] CmdForward  = 8'h01;
  localparam logic [7:0] CmdBackward = 8'h02;
  localparam logic [7:0] CmdBrake    = 8'h03;
  localparam logic [7:0] CmdSpeed    = 8'h04;

  localparam logic [1:0] ModeStop     = 2'd0;
  localparam logic [1:0] ModeBrake    = 2'd1;
  localparam logic [1:0] ModeForward  = 2'd2;
  localparam logic [1:0] ModeBackward = 2'd3;

  localparam logic [1:0] StatusApplied  = 2'd0;
  localparam logic [1:0] StatusBadSum   = 2'd1;
  localparam logic [1:0] StatusTooLarge = 2'd2;

  typedef enum logic [2:0] {
    PhHunt = 3'd0,
    PhCmd  = 3'd1,
    PhLen  = 3'd2,
    PhData = 3'd3,
    PhSum  = 3'd4
  } phase_e;

endpackage

/* rtl/core/motor_command_frame_parser_core.sv */
// Motor command frame parser core: byte parser, speed and mode state, and
// result register. Depends on mcfp_pkg and motor_command_frame_parser_core_macros.svh.
//
// Usage: serial bytes enter on the input channel (in_valid_i, rx_byte_i,
// in_stall_o). Each request is one byte. The parser hunts for header 0xA1,
// then takes command, length, payload and an XOR checksum. The byte that
// completes a frame, or a length byte above MaxPayload, produces one result
// request on the output channel (out_valid_o, out_stall_i and the frame
// fields); every other byte produces none.
// Output: a result is registered and appears on the outputs in the cycle after
// the byte that caused it is accepted. Throughput: one byte per cycle unless
// stalled, set by the single result register; all parsing is done in one pass
// of logic between the state registers.
// Stall: while a result is held and out_stall_i is high, in_stall_o is high
// and no byte is taken; the held result does not change.
// Reset: the parser hunts for a header, both targets are zero, both modes
// are stop, the payload bytes are zero and no result is pending.
`include "motor_command_frame_parser_core_macros.svh"

module motor_command_frame_parser_core #(
  parameter int unsigned MaxPayload = mcfp_pkg::MaxPayloadDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  frame_status_o,
  output logic [7:0]  frame_command_o,
  output logic [15:0] left_setpoint_o,
  output logic [15:0] right_setpoint_o,
  output logic [1:0]  left_mode_o,
  output logic [1:0]  right_mode_o
);

  mcfp_pkg::phase_e phase_q, phase_d;
  logic [7:0]  held_command_q, held_command_d;
  logic [4:0]  held_length_q, held_length_d;
  logic [4:0]  bytes_seen_q, bytes_seen_d;
  logic [7:0]  running_xor_q, running_xor_d;
  logic [7:0]  payload_q [4];
  logic        payload_we;
  logic [15:0] left_speed_q, left_speed_d;
  logic [15:0] right_speed_q, right_speed_d;
  logic [1:0]  left_drive_q, left_drive_d;
  logic [1:0]  right_drive_q, right_drive_d;

  logic        in_accept;
  logic        too_large;
  logic [4:0]  bytes_seen_inc;
  logic        res_valid;
  logic [1:0]  res_status;
  logic [15:0] lval;
  logic [15:0] rval;
  logic        len_nonzero;
  logic        len_four;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q;
  logic [7:0]  command_q;
  logic [15:0] left_setpoint_q;
  logic [15:0] right_setpoint_q;
  logic [1:0]  left_mode_q;
  logic [1:0]  right_mode_q;

  assign in_stall_o     = out_valid_q && out_stall_i;
  assign in_accept      = in_valid_i && !in_stall_o;
  assign too_large      = rx_byte_i > 8'(MaxPayload);
  assign bytes_seen_inc = 5'(bytes_seen_q + 5'd1);

  always_comb begin
    phase_d = phase_q;
    if (in_accept) begin
      unique case (phase_q)
        mcfp_pkg::PhCmd: phase_d = mcfp_pkg::PhLen;
        mcfp_pkg::PhLen: begin
          if (too_large) begin
            phase_d = mcfp_pkg::PhHunt;
          end else if (rx_byte_i[4:0] != 5'd0) begin
            phase_d = mcfp_pkg::PhData;
          end else begin
            phase_d = mcfp_pkg::PhSum;
          end
        end
        mcfp_pkg::PhData: begin
          if (bytes_seen_inc >= held_length_q) begin
            phase_d = mcfp_pkg::PhSum;
          end
        end
        mcfp_pkg::PhSum: phase_d = mcfp_pkg::PhHunt;
        default: begin
          phase_d = (rx_byte_i == mcfp_pkg::HeaderByte) ? mcfp_pkg::PhCmd : mcfp_pkg::PhHunt;
        end
      endcase
    end
  end

  assign len_nonzero = held_length_q != 5'd0;
  assign len_four    = held_length_q >= 5'd4;

  always_comb begin
    lval = 16'd0;
    rval = 16'd0;
    if (len_nonzero) begin
      lval[7:0] = payload_q[0];
    end
    if (held_length_q >= 5'd2) begin
      lval[15:8] = payload_q[1];
    end
    if (len_four) begin
      rval = {payload_q[3], payload_q[2]};
    end
  end

  always_comb begin
    held_command_d = held_command_q;
    held_length_d  = held_length_q;
    bytes_seen_d   = bytes_seen_q;
    running_xor_d  = running_xor_q;
    payload_we     = 1'b0;
    left_speed_d   = left_speed_q;
    right_speed_d  = right_speed_q;
    left_drive_d   = left_drive_q;
    right_drive_d  = right_drive_q;
    res_valid      = 1'b0;
    res_status     = mcfp_pkg::StatusApplied;
    if (in_accept) begin
      unique case (phase_q)
        mcfp_pkg::PhCmd: begin
          held_command_d = rx_byte_i;
          running_xor_d  = running_xor_q ^ rx_byte_i;
        end
        mcfp_pkg::PhLen: begin
          if (too_large) begin
            res_valid  = 1'b1;
            res_status = mcfp_pkg::StatusTooLarge;
          end else begin
            held_length_d = rx_byte_i[4:0];
            running_xor_d = running_xor_q ^ rx_byte_i;
            bytes_seen_d  = 5'd0;
          end
        end
        mcfp_pkg::PhData: begin
          payload_we    = bytes_seen_q < 5'd4;
          running_xor_d = running_xor_q ^ rx_byte_i;
          bytes_seen_d  = bytes_seen_inc;
        end
        mcfp_pkg::PhSum: begin
          res_valid = 1'b1;
          if (rx_byte_i != running_xor_q) begin
            res_status = mcfp_pkg::StatusBadSum;
          end else begin
            res_status = mcfp_pkg::StatusApplied;
            unique case (held_command_q) inside
              mcfp_pkg::CmdForward, mcfp_pkg::CmdBackward: begin
                if (len_nonzero) begin
                  left_speed_d = lval;
                  left_drive_d = (held_command_q == mcfp_pkg::CmdForward) ?
                                 mcfp_pkg::ModeForward : mcfp_pkg::ModeBackward;
                  if (len_four) begin
                    right_speed_d = rval;
                    right_drive_d = left_drive_d;
                  end
                end
              end
              mcfp_pkg::CmdBrake: begin
                left_speed_d  = 16'd0;
                right_speed_d = 16'd0;
                left_drive_d  = mcfp_pkg::ModeBrake;
                right_drive_d = mcfp_pkg::ModeBrake;
              end
              mcfp_pkg::CmdSpeed: begin
                if (len_nonzero) begin
                  if (left_drive_q[1]) begin
                    left_speed_d = lval;
                  end
                  if (len_four && right_drive_q[1]) begin
                    right_speed_d = rval;
                  end
                end
              end
              default: begin
                left_speed_d  = 16'd0;
                right_speed_d = 16'd0;
                left_drive_d  = mcfp_pkg::ModeStop;
                right_drive_d = mcfp_pkg::ModeStop;
              end
            endcase
          end
        end
        default: begin
          if (rx_byte_i == mcfp_pkg::HeaderByte) begin
            running_xor_d = mcfp_pkg::HeaderByte;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= mcfp_pkg::PhHunt;
      held_command_q <= 8'd0;
      held_length_q  <= 5'd0;
      bytes_seen_q   <= 5'd0;
      running_xor_q  <= 8'd0;
      payload_q[0]   <= 8'd0;
      payload_q[1]   <= 8'd0;
      payload_q[2]   <= 8'd0;
      payload_q[3]   <= 8'd0;
      left_speed_q   <= 16'd0;
      right_speed_q  <= 16'd0;
      left_drive_q   <= mcfp_pkg::ModeStop;
      right_drive_q  <= mcfp_pkg::ModeStop;
      out_valid_q    <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      held_command_q <= held_command_d;
      held_length_q  <= held_length_d;
      bytes_seen_q   <= bytes_seen_d;
      running_xor_q  <= running_xor_d;
      if (payload_we) begin
        payload_q[bytes_seen_q[1:0]] <= rx_byte_i;
      end
      left_speed_q   <= left_speed_d;
      right_speed_q  <= right_speed_d;
      left_drive_q   <= left_drive_d;
      right_drive_q  <= right_drive_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid) begin
      status_q         <= res_status;
      command_q        <= held_command_q;
      left_setpoint_q  <= left_speed_d;
      right_setpoint_q <= right_speed_d;
      left_mode_q      <= left_drive_d;
      right_mode_q     <= right_drive_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_status_o   = status_q;
  assign frame_command_o  = command_q;
  assign left_setpoint_o  = left_setpoint_q;
  assign right_setpoint_o = right_setpoint_q;
  assign left_mode_o      = left_mode_q;
  assign right_mode_o     = right_mode_q;

  `MCFP_ASSERT(a_result_phase,
               (in_accept && res_valid) |->
               (phase_q == mcfp_pkg::PhSum || phase_q == mcfp_pkg::PhLen))
  `MCFP_ASSERT_NEXT(a_sum_returns_hunt, in_accept && phase_q == mcfp_pkg::PhSum,
                    phase_q == mcfp_pkg::PhHunt)
  `MCFP_ASSERT(a_stall_needs_result, in_stall_o |-> out_valid_q)
  `MCFP_ASSERT(a_data_count_bound,
               (phase_q == mcfp_pkg::PhData) |-> (bytes_seen_q < held_length_q))
  `MCFP_ASSERT_NEXT(a_stop_clears,
                    in_accept && res_valid && res_status == mcfp_pkg::StatusApplied &&
                    held_command_q == mcfp_pkg::CmdStop,
                    left_setpoint_o == 16'd0 && right_setpoint_o == 16'd0)

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for motor_command_frame_parser_core: random serial byte streams
// with framed commands, a cycle-level parser predictor and in-order frame report checks.
// Depends on mcfp_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned StreamBytes = 2040;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  command;
    logic [15:0] left_setpoint;
    logic [15:0] right_setpoint;
    logic [1:0]  left_mode;
    logic [1:0]  right_mode;
  } frame_report_t;

  typedef struct {
    logic [7:0] data;
    bit         drain;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  frame_status_o;
  logic [7:0]  frame_command_o;
  logic [15:0] left_setpoint_o;
  logic [15:0] right_setpoint_o;
  logic [1:0]  left_mode_o;
  logic [1:0]  right_mode_o;

  rx_item_t      rx_feed[$];
  frame_report_t due_reports[$];
  logic [7:0]    frame_body[16];

  int unsigned send_gap = 0;
  int unsigned sent_n = 0;
  int unsigned recv_wait = 0;
  int unsigned hold_left = 0;
  int unsigned taken_n = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned n_applied = 0;
  int unsigned n_bad_sum = 0;
  int unsigned n_oversize = 0;

  mcfp_pkg::phase_e prs_phase = mcfp_pkg::PhHunt;
  logic [7:0]  prs_command = 8'h00;
  logic [4:0]  prs_length = 5'd0;
  logic [4:0]  prs_seen = 5'd0;
  logic [7:0]  prs_xor = 8'h00;
  logic [7:0]  prs_payload[4] = '{8'h00, 8'h00, 8'h00, 8'h00};
  logic [15:0] left_speed = 16'h0000;
  logic [15:0] right_speed = 16'h0000;
  logic [1:0]  left_drive = mcfp_pkg::ModeStop;
  logic [1:0]  right_drive = mcfp_pkg::ModeStop;

  motor_command_frame_parser_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_status_o  (frame_status_o),
    .frame_command_o (frame_command_o),
    .left_setpoint_o (left_setpoint_o),
    .right_setpoint_o(right_setpoint_o),
    .left_mode_o     (left_mode_o),
    .right_mode_o    (right_mode_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void post_report(input logic [1:0] status);
    frame_report_t rpt;
    rpt.status         = status;
    rpt.command        = prs_command;
    rpt.left_setpoint  = left_speed;
    rpt.right_setpoint = right_speed;
    rpt.left_mode      = left_drive;
    rpt.right_mode     = right_drive;
    due_reports.push_back(rpt);
  endfunction

  function automatic void set_both_sides(input logic [1:0] mode);
    left_speed  = 16'h0000;
    right_speed = 16'h0000;
    left_drive  = mode;
    right_drive = mode;
  endfunction

  function automatic void apply_frame();
    logic [15:0] lval;
    logic [15:0] rval;
    logic [1:0]  mode;
    lval = 16'h0000;
    rval = 16'h0000;
    if (prs_length >= 5'd1) lval[7:0] = prs_payload[0];
    if (prs_length >= 5'd2) lval[15:8] = prs_payload[1];
    if (prs_length >= 5'd4) rval = {prs_payload[3], prs_payload[2]};
    case (prs_command)
      mcfp_pkg::CmdStop: set_both_sides(mcfp_pkg::ModeStop);
      mcfp_pkg::CmdForward, mcfp_pkg::CmdBackward: begin
        mode = (prs_command == mcfp_pkg::CmdForward) ? mcfp_pkg::ModeForward
                                                     : mcfp_pkg::ModeBackward;
        if (prs_length != 5'd0) begin
          left_speed = lval;
          left_drive = mode;
          if (prs_length >= 5'd4) begin
            right_speed = rval;
            right_drive = mode;
          end
        end
      end
      mcfp_pkg::CmdBrake: set_both_sides(mcfp_pkg::ModeBrake);
      mcfp_pkg::CmdSpeed: begin
        if (prs_length != 5'd0) begin
          if (left_drive == mcfp_pkg::ModeForward || left_drive == mcfp_pkg::ModeBackward)
            left_speed = lval;
          if (prs_length >= 5'd4 && (right_drive == mcfp_pkg::ModeForward ||
                                     right_drive == mcfp_pkg::ModeBackward))
            right_speed = rval;
        end
      end
      default: set_both_sides(mcfp_pkg::ModeStop);
    endcase
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    case (prs_phase)
      mcfp_pkg::PhCmd: begin
        prs_command = b;
        prs_xor ^= b;
        prs_phase = mcfp_pkg::PhLen;
      end
      mcfp_pkg::PhLen: begin
        if (b > mcfp_pkg::MaxPayloadDefault) begin
          prs_phase = mcfp_pkg::PhHunt;
          post_report(mcfp_pkg::StatusTooLarge);
        end else begin
          prs_length = b[4:0];
          prs_xor ^= b;
          prs_seen = 5'd0;
          prs_phase = (prs_length != 5'd0) ? mcfp_pkg::PhData : mcfp_pkg::PhSum;
        end
      end
      mcfp_pkg::PhData: begin
        if (prs_seen < 5'd4) prs_payload[prs_seen[1:0]] = b;
        prs_xor ^= b;
        prs_seen = prs_seen + 5'd1;
        if (prs_seen >= prs_length) prs_phase = mcfp_pkg::PhSum;
      end
      mcfp_pkg::PhSum: begin
        prs_phase = mcfp_pkg::PhHunt;
        if (b != prs_xor) begin
          post_report(mcfp_pkg::StatusBadSum);
        end else begin
          apply_frame();
          post_report(mcfp_pkg::StatusApplied);
        end
      end
      default: begin
        prs_phase = mcfp_pkg::PhHunt;
        if (b == mcfp_pkg::HeaderByte) begin
          prs_xor = mcfp_pkg::HeaderByte;
          prs_phase = mcfp_pkg::PhCmd;
        end
      end
    endcase
  endfunction

  task automatic log_fault(input string msg);
    fail_count++;
    $display("%0t ns: %s", $realtime, msg);
  endtask

  task automatic cmp_field(input string what, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      log_fault($sformatf("report %0d: %s is %0h, predicted %0h", taken_n, what, got, want));
  endtask

  task automatic push_byte(input logic [7:0] data, input bit drain);
    rx_item_t item;
    item.data  = data;
    item.drain = drain;
    rx_feed.push_back(item);
  endtask

  task automatic push_frame(input logic [7:0] cmd, input logic [7:0] len, input bit bad_sum,
                            input bit drain);
    logic [7:0] sum;
    sum = mcfp_pkg::HeaderByte ^ cmd ^ len;
    push_byte(mcfp_pkg::HeaderByte, drain);
    push_byte(cmd, 1'b0);
    push_byte(len, 1'b0);
    for (int i = 0; i < len; i++) begin
      push_byte(frame_body[i], 1'b0);
      sum ^= frame_body[i];
    end
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    push_byte(sum, 1'b0);
  endtask

  // The sender presents one byte per request and holds it while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i <= 8'h00;
      send_gap <= 0;
      sent_n <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) sent_n <= sent_n + 1;
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (rx_feed.size() != 0 && (!rx_feed[0].drain ||
                     (!in_valid_i && !out_valid_o && due_reports.size() == 0))) begin
          in_valid_i <= 1'b1;
          rx_byte_i <= rx_feed[0].data;
          send_gap <= ((sent_n / 300) % 3 == 1) ? 0 : $urandom_range(0, 7);
          void'(rx_feed.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // The receiver stalls a random number of cycles after each request and twice holds off
  // for a long stretch so that the core backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned w;
    int unsigned h;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait <= 0;
      hold_left <= 0;
      taken_n <= 0;
    end else begin
      w = recv_wait;
      h = hold_left;
      if (out_valid_o && !out_stall_i) begin
        taken_n <= taken_n + 1;
        w = ((taken_n / 25) % 4 == 2) ? 0 : $urandom_range(0, 7);
        if (taken_n == 20 || taken_n == 150) h = HoldCycles;
      end else if (w != 0) begin
        w--;
      end
      if (h != 0) h--;
      recv_wait <= w;
      hold_left <= h;
      out_stall_i <= (w != 0) || (h != 0);
    end
  end

  always @(posedge clk_i) begin
    frame_report_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_reports.size() == 0) begin
          log_fault($sformatf("report %0d arrived with none predicted", taken_n));
        end else begin
          want = due_reports.pop_front();
          case (want.status)
            mcfp_pkg::StatusApplied: n_applied++;
            mcfp_pkg::StatusBadSum: n_bad_sum++;
            default: n_oversize++;
          endcase
          cmp_field("frame_status", 16'(frame_status_o), 16'(want.status));
          cmp_field("frame_command", 16'(frame_command_o), 16'(want.command));
          cmp_field("left_setpoint", left_setpoint_o, want.left_setpoint);
          cmp_field("right_setpoint", right_setpoint_o, want.right_setpoint);
          cmp_field("left_mode", 16'(left_mode_o), 16'(want.left_mode));
          cmp_field("right_mode", 16'(right_mode_o), 16'(want.right_mode));
        end
      end
      if (in_valid_i && !in_stall_o) parse_byte(rx_byte_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("Timed out after %0d cycles without a request, %0d reports outstanding.",
                 IdleLimit, due_reports.size());
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] known_cmds[5];
    logic [7:0] cmd;
    int unsigned kind;
    int unsigned len;
    int unsigned next_drain;
    bit drain;
    known_cmds = '{mcfp_pkg::CmdStop, mcfp_pkg::CmdForward, mcfp_pkg::CmdBackward,
                   mcfp_pkg::CmdBrake, mcfp_pkg::CmdSpeed};

    push_byte(8'h00, 1'b0);
    frame_body[0] = 8'hFF;
    push_frame(mcfp_pkg::CmdForward, 8'd1, 1'b0, 1'b0);
    frame_body[0] = 8'h34;
    frame_body[1] = 8'h12;
    frame_body[2] = 8'h77;
    push_frame(mcfp_pkg::CmdSpeed, 8'd3, 1'b0, 1'b0);
    frame_body[0] = 8'h00;
    frame_body[1] = 8'h80;
    frame_body[2] = 8'hFF;
    frame_body[3] = 8'hFF;
    frame_body[4] = 8'h5A;
    push_frame(mcfp_pkg::CmdBackward, 8'd5, 1'b0, 1'b0);
    push_frame(mcfp_pkg::CmdBrake, 8'd0, 1'b1, 1'b0);
    push_byte(mcfp_pkg::HeaderByte, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_frame(mcfp_pkg::CmdStop, 8'd0, 1'b0, 1'b0);

    next_drain = rx_feed.size();
    while (rx_feed.size() < StreamBytes) begin
      drain = (rx_feed.size() >= next_drain);
      if (drain) next_drain += 500;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        push_byte(8'($urandom_range(0, 255)), drain);
      end else if (kind < 14) begin
        len = $urandom_range(1, mcfp_pkg::MaxPayloadDefault);
        push_byte(mcfp_pkg::HeaderByte, drain);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(8'(len), 1'b0);
        repeat ($urandom_range(0, len - 1)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 20) begin
        push_byte(mcfp_pkg::HeaderByte, drain);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(8'($urandom_range(mcfp_pkg::MaxPayloadDefault + 1, 255)), 1'b0);
      end else begin
        kind = $urandom_range(0, 5);
        cmd = (kind < 5) ? known_cmds[kind] : 8'($urandom_range(0, 255));
        len = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 5)
                                          : $urandom_range(6, mcfp_pkg::MaxPayloadDefault);
        for (int i = 0; i < 16; i++) frame_body[i] = 8'($urandom_range(0, 255));
        push_frame(cmd, 8'(len), $urandom_range(0, 9) == 0, drain);
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_feed.size() != 0 || in_valid_i || due_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d serial bytes; checked %0d frame reports.", sent_n, taken_n);
    $display("Reports: %0d applied, %0d checksum errors, %0d oversize lengths.",
             n_applied, n_bad_sum, n_oversize);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found.", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
